[hw/rtl/wmab_pkg.sv]
// shared constants and types for the weighted moving average bank
`timescale 1ns / 1ps

package wmab_pkg;

  localparam int CHANNELS_PER_GROUP = 5;
  localparam int GROUPS             = 2;
  localparam int NUM_LANES          = GROUPS * CHANNELS_PER_GROUP;
  localparam int SAMPLE_WIDTH       = 16;
  localparam int MAX_WINDOW         = 16;

  localparam int WIN_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [WIN_W-1:0] RESET_WINDOW = WIN_W'(10);

  localparam logic [CFG_IDX_W-1:0] REG_VEL_WINDOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WINDOW = CFG_IDX_W'(1);

  typedef struct packed {
    logic capture;
    logic update;
    logic restart;
    logic full;
  } grp_ctrl_t;

endpackage

[hw/rtl/weighted_moving_average_bank_core.sv]
// top level: group control, lane array and output merge register
`timescale 1ns / 1ps

// Linear weighted moving average over five velocity and five temperature
// channels, one window length per group.
// Input channel: in_valid_i / in_stall_o with ten signed Q8.8 samples; a
// transaction is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with ten signed Q8.8 averages,
// one result per input transaction.
// Config channel: cfg_valid_i / cfg_ready_o, index 0 velocity window,
// index 1 temperature window; a write restarts that group's warm-up.
// Input stall is also high while a config write is offered.
// Path from input to output valid: sample capture, the update state, the
// bit-serial divider in each lane (weighted sum width 24 at the default
// maximum window of 16), the merge state and the output register. Only
// one transaction is in the lanes at a time: input stall is high from
// acceptance until the result moves into the output register.
// A finished result waits in the output register while the receiver
// stalls; the next input is taken meanwhile, its result held until free.
// Reset: both windows return to 10, all sums and fill counts clear.

module weighted_moving_average_bank_core #(
  parameter int MaxWindow = wmab_pkg::MAX_WINDOW
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_0_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_1_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_2_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_3_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_4_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_0_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_1_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_2_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_3_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_4_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_avg_0_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_avg_1_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_avg_2_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_avg_3_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] vel_avg_4_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_avg_0_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_avg_1_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_avg_2_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_avg_3_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] temp_avg_4_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [wmab_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [wmab_pkg::WIN_W-1:0]              cfg_data_i
);
  import wmab_pkg::*;

  localparam int NW    = $clog2(MaxWindow + 1);
  localparam int PtrW  = $clog2(MaxWindow);
  localparam int Tri   = MaxWindow * (MaxWindow + 1) / 2;
  localparam int DvW   = $clog2(Tri + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_DIV, ST_OUT} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q [NUM_LANES];

  logic accept;
  logic out_load;
  logic [GROUPS-1:0] cfg_sel;

  logic [WIN_W-1:0] win_q   [GROUPS];
  logic [NW-1:0]    fill_q  [GROUPS];
  logic [PtrW-1:0]  wp_q    [GROUPS];
  logic [NW-1:0]    held_q  [GROUPS];
  logic             full_q  [GROUPS];
  logic [DvW-1:0]   dvs_q   [GROUPS];

  logic [NW-1:0]    eff     [GROUPS];
  logic             full_d  [GROUPS];
  logic [NW-1:0]    held_d  [GROUPS];
  logic [2*NW:0]    tri_d   [GROUPS];
  logic [PtrW-1:0]  raddr   [GROUPS];
  logic [NW:0]      wp_ext  [GROUPS];
  logic [NW:0]      eff_ext [GROUPS];

  grp_ctrl_t grp_ctrl [GROUPS];

  logic signed [SAMPLE_WIDTH-1:0] samples [NUM_LANES];
  logic signed [SAMPLE_WIDTH-1:0] avgs    [NUM_LANES];
  logic [NUM_LANES-1:0]           lane_busy;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign cfg_sel[0]  = cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_VEL_WINDOW);
  assign cfg_sel[1]  = cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_TEMP_WINDOW);
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      if (win_q[g] == '0) begin
        eff[g] = NW'(1);
      end else if (32'(win_q[g]) > MaxWindow) begin
        eff[g] = NW'(MaxWindow);
      end else begin
        eff[g] = NW'(win_q[g]);
      end
      full_d[g]  = fill_q[g] >= eff[g];
      held_d[g]  = full_d[g] ? eff[g] : fill_q[g] + 1'b1;
      tri_d[g]   = (2*NW+1)'(held_d[g]) * (2*NW+1)'(held_d[g] + 1'b1);
      wp_ext[g]  = (NW+1)'(wp_q[g]);
      eff_ext[g] = (NW+1)'(eff[g]);
      if (wp_ext[g] >= eff_ext[g]) begin
        raddr[g] = PtrW'(wp_ext[g] - eff_ext[g]);
      end else begin
        raddr[g] = PtrW'(wp_ext[g] + (NW+1)'(MaxWindow) - eff_ext[g]);
      end
      grp_ctrl[g].capture = accept;
      grp_ctrl[g].update  = state_q == ST_UPD;
      grp_ctrl[g].restart = cfg_sel[g];
      grp_ctrl[g].full    = full_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) begin
        win_q[g]  <= RESET_WINDOW;
        fill_q[g] <= '0;
        wp_q[g]   <= '0;
        held_q[g] <= '0;
        full_q[g] <= 1'b0;
        dvs_q[g]  <= '0;
      end
    end else begin
      for (int g = 0; g < GROUPS; g++) begin
        if (cfg_sel[g]) begin
          win_q[g]  <= cfg_data_i;
          fill_q[g] <= '0;
        end else if (state_q == ST_UPD) begin
          fill_q[g] <= held_q[g];
          wp_q[g]   <= (wp_q[g] == PtrW'(MaxWindow - 1)) ? '0 : wp_q[g] + 1'b1;
        end
        if (accept) begin
          held_q[g] <= held_d[g];
          full_q[g] <= full_d[g];
          dvs_q[g]  <= DvW'(tri_d[g] >> 1);
        end
      end
    end
  end

  assign samples[0] = vel_0_i;
  assign samples[1] = vel_1_i;
  assign samples[2] = vel_2_i;
  assign samples[3] = vel_3_i;
  assign samples[4] = vel_4_i;
  assign samples[5] = temp_0_i;
  assign samples[6] = temp_1_i;
  assign samples[7] = temp_2_i;
  assign samples[8] = temp_3_i;
  assign samples[9] = temp_4_i;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    localparam int Grp = i / CHANNELS_PER_GROUP;
    wmab_lane #(
      .MaxWindow (MaxWindow)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (grp_ctrl[Grp]),
      .sample_i  (samples[i]),
      .held_i    (held_q[Grp]),
      .raddr_i   (raddr[Grp]),
      .waddr_i   (wp_q[Grp]),
      .divisor_i (dvs_q[Grp]),
      .busy_o    (lane_busy[i]),
      .avg_o     (avgs[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        out_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (lane_busy == '0) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            for (int i = 0; i < NUM_LANES; i++) begin
              out_q[i] <= avgs[i];
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vel_avg_0_o  = out_q[0];
  assign vel_avg_1_o  = out_q[1];
  assign vel_avg_2_o  = out_q[2];
  assign vel_avg_3_o  = out_q[3];
  assign vel_avg_4_o  = out_q[4];
  assign temp_avg_0_o = out_q[5];
  assign temp_avg_1_o = out_q[6];
  assign temp_avg_2_o = out_q[7];
  assign temp_avg_3_o = out_q[8];
  assign temp_avg_4_o = out_q[9];

`ifndef ASSERT_OFF
  a_accept_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_UPD)
    else $error("accepted transaction did not start an update");

  a_update_starts_dividers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |=> lane_busy == '1)
    else $error("lane dividers not running after update");

  a_vel_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= eff[0])
    else $error("velocity fill count above window");

  a_temp_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[1] <= eff[1])
    else $error("temperature fill count above window");

  a_result_from_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output valid rose outside merge state");
`endif

endmodule

[hw/rtl/wmab_div.sv]
// serial signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps

module wmab_div #(
  parameter int WsWidth = 24,
  parameter int DvWidth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [WsWidth-1:0]               dividend_i,
  input  logic        [DvWidth-1:0]               divisor_i,
  output logic                                    busy_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] quotient_o
);
  import wmab_pkg::*;

  localparam int CntW = $clog2(WsWidth + 1);

  logic               busy_q;
  logic [CntW-1:0]    cnt_q;
  logic               neg_q;
  logic [WsWidth-1:0] quo_q;
  logic [DvWidth-1:0] div_q;
  logic [DvWidth-1:0] rem_q;
  logic [DvWidth:0]   trial;
  logic               fits;
  logic [WsWidth-1:0] signed_quo;

  assign trial = {rem_q, quo_q[WsWidth-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(WsWidth);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= cnt_q != CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[WsWidth-1];
      quo_q <= dividend_i[WsWidth-1] ? -dividend_i : dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DvWidth'(trial - {1'b0, div_q}) : DvWidth'(trial);
      quo_q <= {quo_q[WsWidth-2:0], fits};
    end
  end

  assign signed_quo = neg_q ? -quo_q : quo_q;
  assign quotient_o = signed_quo[SAMPLE_WIDTH-1:0];
  assign busy_o     = busy_q;

endmodule

[hw/rtl/wmab_lane.sv]
// one channel lane: sample history, running sums and divider
`timescale 1ns / 1ps

module wmab_lane #(
  parameter int MaxWindow = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  wmab_pkg::grp_ctrl_t                     ctrl_i,
  input  logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic [$clog2(MaxWindow+1)-1:0]          held_i,
  input  logic [$clog2(MaxWindow)-1:0]            raddr_i,
  input  logic [$clog2(MaxWindow)-1:0]            waddr_i,
  input  logic [$clog2(MaxWindow*(MaxWindow+1)/2+1)-1:0] divisor_i,
  output logic                                    busy_o,
  output logic signed [wmab_pkg::SAMPLE_WIDTH-1:0] avg_o
);
  import wmab_pkg::*;

  localparam int NW    = $clog2(MaxWindow + 1);
  localparam int Tri   = MaxWindow * (MaxWindow + 1) / 2;
  localparam int WsW   = SAMPLE_WIDTH + $clog2(Tri);
  localparam int PsW   = SAMPLE_WIDTH + $clog2(MaxWindow + 1);
  localparam int DvW   = $clog2(Tri + 1);

  logic signed [SAMPLE_WIDTH-1:0] hist_mem [MaxWindow];
  logic signed [SAMPLE_WIDTH-1:0] rdata_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [WsW-1:0]          ws_q, ws_d;
  logic signed [PsW-1:0]          ps_q, ps_d;
  logic signed [SAMPLE_WIDTH+NW:0] prod;

  assign prod = x_q * $signed({1'b0, held_i});

  always_comb begin
    ws_d = ws_q + WsW'(prod) - (ctrl_i.full ? WsW'(ps_q) : WsW'(0));
    ps_d = ps_q + PsW'(x_q) - (ctrl_i.full ? PsW'(rdata_q) : PsW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
      ps_q <= '0;
    end else if (ctrl_i.restart) begin
      ws_q <= '0;
      ps_q <= '0;
    end else if (ctrl_i.update) begin
      ws_q <= ws_d;
      ps_q <= ps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      x_q <= sample_i;
    end
  end

  // circular history, oldest sample read into a register ahead of the update
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      hist_mem[waddr_i] <= x_q;
    end
    rdata_q <= hist_mem[raddr_i];
  end

  wmab_div #(
    .WsWidth (WsW),
    .DvWidth (DvW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.update),
    .dividend_i (ws_d),
    .divisor_i  (divisor_i),
    .busy_o     (busy_o),
    .quotient_o (avg_o)
  );

endmodule

[sim/weighted_moving_average_bank_core_tb.sv]
// self-checking testbench for the weighted moving average bank core
`timescale 1ns / 1ps

module weighted_moving_average_bank_core_tb;
  import wmab_pkg::*;

  typedef logic [NUM_LANES-1:0][SAMPLE_WIDTH-1:0] frame_t;

  typedef enum {
    PACE_FULL_RATE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH_IDLE
  } pace_e;

  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 16'h8000;
  localparam int SKIP_WRITE = -1;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  class lwma_tracker;
    logic [WIN_W-1:0]        window_reg [GROUPS];
    int unsigned             fill_count [GROUPS];
    longint                  weighted_sum [NUM_LANES];
    longint                  plain_sum [NUM_LANES];
    logic [SAMPLE_WIDTH-1:0] history [NUM_LANES][MAX_WINDOW];
    frame_t                  expected_avgs [$];
    int                      mismatches;

    function new();
      mismatches = 0;
      foreach (history[i, j]) history[i][j] = '0;
      for (int g = 0; g < GROUPS; g++) set_window(g, RESET_WINDOW);
    endfunction

    function void set_window(int g, logic [WIN_W-1:0] value);
      window_reg[g] = value;
      fill_count[g] = 0;
      for (int c = 0; c < CHANNELS_PER_GROUP; c++) begin
        weighted_sum[g * CHANNELS_PER_GROUP + c] = 0;
        plain_sum[g * CHANNELS_PER_GROUP + c] = 0;
      end
    endfunction

    function int unsigned window_len(int g);
      if (window_reg[g] == 0) return 1;
      if (window_reg[g] > MAX_WINDOW) return MAX_WINDOW;
      return window_reg[g];
    endfunction

    function void note_frame(frame_t samples);
      frame_t avgs;
      int unsigned n;
      int unsigned held;
      longint divisor;
      longint x;
      longint leaving;
      longint avg;
      bit full;
      int ch;
      for (int g = 0; g < GROUPS; g++) begin
        n = window_len(g);
        full = (fill_count[g] >= n);
        held = full ? n : fill_count[g] + 1;
        divisor = held * (held + 1) / 2;
        for (int c = 0; c < CHANNELS_PER_GROUP; c++) begin
          ch = g * CHANNELS_PER_GROUP + c;
          x = $signed(samples[ch]);
          if (full) begin
            leaving = $signed(history[ch][n-1]);
            weighted_sum[ch] += longint'(n) * x - plain_sum[ch];
            plain_sum[ch] += x - leaving;
          end else begin
            weighted_sum[ch] += longint'(held) * x;
            plain_sum[ch] += x;
          end
          for (int k = MAX_WINDOW - 1; k > 0; k--) history[ch][k] = history[ch][k-1];
          history[ch][0] = samples[ch];
          avg = weighted_sum[ch] / divisor;
          avgs[ch] = avg[SAMPLE_WIDTH-1:0];
        end
        fill_count[g] = held;
      end
      expected_avgs.insert(expected_avgs.size(), avgs);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_avgs(frame_t got);
      frame_t want;
      int c;
      if (expected_avgs.size() == 0) begin
        report_mismatch("result transaction with no frame pending");
        return;
      end
      want = expected_avgs[0];
      expected_avgs.delete(0);
      for (int ch = 0; ch < NUM_LANES; ch++) begin
        c = ch % CHANNELS_PER_GROUP;
        if (got[ch] !== want[ch])
          report_mismatch($sformatf("%s_avg_%0d got %0d expected %0d",
                          (ch < CHANNELS_PER_GROUP) ? "vel" : "temp", c,
                          $signed(got[ch]), $signed(want[ch])));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  frame_t in_frame = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_VEL_WINDOW;
  logic [WIN_W-1:0] cfg_data = '0;

  wire in_stall;
  wire out_valid;
  wire cfg_ready;
  wire [NUM_LANES-1:0][SAMPLE_WIDTH-1:0] avg_bus;

  lwma_tracker tracker = new();
  pace_e pace = PACE_FULL_RATE;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  weighted_moving_average_bank_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .vel_0_i      (in_frame[0]),
    .vel_1_i      (in_frame[1]),
    .vel_2_i      (in_frame[2]),
    .vel_3_i      (in_frame[3]),
    .vel_4_i      (in_frame[4]),
    .temp_0_i     (in_frame[5]),
    .temp_1_i     (in_frame[6]),
    .temp_2_i     (in_frame[7]),
    .temp_3_i     (in_frame[8]),
    .temp_4_i     (in_frame[9]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .vel_avg_0_o  (avg_bus[0]),
    .vel_avg_1_o  (avg_bus[1]),
    .vel_avg_2_o  (avg_bus[2]),
    .vel_avg_3_o  (avg_bus[3]),
    .vel_avg_4_o  (avg_bus[4]),
    .temp_avg_0_o (avg_bus[5]),
    .temp_avg_1_o (avg_bus[6]),
    .temp_avg_2_o (avg_bus[7]),
    .temp_avg_3_o (avg_bus[8]),
    .temp_avg_4_o (avg_bus[9]),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  function automatic int idle_pct(bit receiver_side);
    if (pace == PACE_BOTH_IDLE) return 8;
    if (receiver_side && pace == PACE_RECEIVER_STALL) return 83;
    if (!receiver_side && pace == PACE_SENDER_IDLE) return 83;
    return 0;
  endfunction

  function automatic frame_t split_frame(logic [SAMPLE_WIDTH-1:0] even_val,
                                         logic [SAMPLE_WIDTH-1:0] odd_val);
    frame_t f;
    for (int ch = 0; ch < NUM_LANES; ch++) f[ch] = (ch % 2 == 0) ? even_val : odd_val;
    return f;
  endfunction

  function automatic frame_t random_frame(int extreme_pct);
    frame_t f;
    int r;
    for (int ch = 0; ch < NUM_LANES; ch++) begin
      r = $urandom_range(0, 99);
      if (r < extreme_pct) f[ch] = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      else if (r < extreme_pct + 10) f[ch] = SAMPLE_WIDTH'($urandom_range(0, 16) - 8);
      else f[ch] = SAMPLE_WIDTH'($urandom);
    end
    return f;
  endfunction

  function automatic int pick_window();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return SKIP_WRITE;
    if (r < 5) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 1;
        2: return MAX_WINDOW;
        default: return 31;
      endcase
    end
    return $urandom_range(0, 31);
  endfunction

  // result side: random stall, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) tracker.check_avgs(avg_bus);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
      end
    end
  end

  task automatic offer_frame(frame_t f);
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame <= f;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_frame(f);
  endtask

  task automatic program_windows(int vel_win, int temp_win);
    int wins [GROUPS];
    bit wrote;
    wins[0] = vel_win;
    wins[1] = temp_win;
    wrote = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      if (wins[g] != SKIP_WRITE) begin
        cfg_valid <= 1'b1;
        cfg_index <= (g == 0) ? REG_VEL_WINDOW : REG_TEMP_WINDOW;
        cfg_data <= WIN_W'(wins[g]);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker.set_window(g, WIN_W'(wins[g]));
        wrote = 1'b1;
      end
    end
    if (wrote) cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (tracker.expected_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int first_vel [4];
    int first_temp [4];
    first_vel = '{1, MAX_WINDOW, 31, MAX_WINDOW};
    first_temp = '{MAX_WINDOW, 0, 2, MAX_WINDOW};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset windows: warm-up, full window at both extremes, leaving samples
    offer_frame('0);
    repeat (10) offer_frame(split_frame(SAMPLE_MAX, SAMPLE_MAX));
    repeat (3) offer_frame(split_frame(SAMPLE_MIN, SAMPLE_MIN));
    offer_frame(split_frame(16'hffff, 16'h0001));
    offer_frame(split_frame(16'h5555, 16'haaaa));
    in_valid <= 1'b0;
    settle();

    // zero window acts as one, oversized window acts as maximum
    program_windows(0, 31);
    offer_frame(split_frame(SAMPLE_MAX, SAMPLE_MIN));
    offer_frame(split_frame(SAMPLE_MIN, SAMPLE_MAX));
    offer_frame(split_frame(16'haaaa, 16'h5555));
    in_valid <= 1'b0;
    settle();

    // rewrite of the same value restarts warm-up
    program_windows(MAX_WINDOW, MAX_WINDOW + 1);
    offer_frame(split_frame(SAMPLE_MAX, 16'h0100));
    offer_frame(split_frame(16'hff00, SAMPLE_MIN));
    in_valid <= 1'b0;
    settle();
    program_windows(MAX_WINDOW, SKIP_WRITE);
    offer_frame(split_frame(SAMPLE_MIN, SAMPLE_MAX));
    offer_frame(split_frame(16'h0001, 16'hffff));
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < 13; p++) begin
      pace = pace_e'(p % 4);
      if (p < 4) program_windows(first_vel[p], first_temp[p]);
      else program_windows(pick_window(), pick_window());
      if (p == 6) hold_left = HOLD_OFF_CYCLES;
      for (int i = 0; i < 100; i++) offer_frame(random_frame((p == 3) ? 80 : 15));
      in_valid <= 1'b0;
      settle();
    end

    if (tracker.mismatches == 0 && tracker.expected_avgs.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[weighted_moving_average_bank_core.f]
hw/rtl/wmab_pkg.sv
hw/rtl/wmab_div.sv
hw/rtl/wmab_lane.sv
hw/rtl/weighted_moving_average_bank_core.sv
sim/weighted_moving_average_bank_core_tb.sv
